// ===== rtl/atmd_pkg.sv =====
// Shared constants, types and elaboration-time CORDIC tables for the tilt detector.
package atmd_pkg;

  localparam int unsigned SampleW   = 16;
  localparam int unsigned AngleFrac = 7;
  localparam int unsigned AngleW    = AngleFrac + 8;
  localparam int unsigned Steps     = 40;
  localparam int unsigned NormW     = 41;
  localparam int unsigned RotW      = 48;
  localparam int unsigned GainW     = 21;
  localparam logic [GainW-1:0] GainQ20 = 21'd1726753;
  localparam int unsigned DegW      = 8 + AngleFrac;
  localparam logic [DegW-1:0] DegMul = DegW'(180 << AngleFrac);
  localparam logic [AngleW-1:0] AngleMax = AngleW'(90 << AngleFrac);
  localparam int unsigned ThrW      = 14;
  localparam int unsigned LenW      = 8;

  // configuration register indexes
  localparam logic CfgWindowLength = 1'b0;
  localparam logic CfgTiltThreshold = 1'b1;

  localparam logic [LenW-1:0] WindowLengthRst = 8'd100;
  localparam logic [ThrW-1:0] TiltThresholdRst = 14'd1920;

  typedef logic [63:0] atan_tab_t [Steps];

  typedef struct packed {
    logic        start;
    logic        flag;
  } win_req_t;

  function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int k = 63; k >= 0; k--) begin
      r = {r[62:0], n[k]};
      if (r >= d) begin
        r = r - d;
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] atan_series(input logic [63:0] first,
                                              input logic [63:0] sq,
                                              input int unsigned sh);
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] t;
    logic [63:0] k;
    logic        neg;
    p   = first;
    sum = first;
    k   = 64'd1;
    neg = 1'b1;
    for (int it = 0; it < 64; it++) begin
      if (sq != 0) p = udiv(p, sq);
      else p = (sh < 64) ? (p >> sh) : 64'd0;
      if (p == 0) break;
      t   = udiv(p, 2 * k + 1);
      sum = neg ? sum - t : sum + t;
      neg = !neg;
      k   = k + 1;
    end
    return sum;
  endfunction

  // atan(1) by Machin's formula, Q61
  function automatic logic [63:0] atan_quarter();
    logic [63:0] one;
    logic [63:0] a5;
    logic [63:0] a239;
    one  = 64'd1 << 61;
    a5   = atan_series(udiv(one, 64'd5), 64'd25, 0);
    a239 = atan_series(udiv(one, 64'd239), 64'd57121, 0);
    return 4 * a5 - a239;
  endfunction

  function automatic atan_tab_t build_atan();
    atan_tab_t tab;
    logic [63:0] one;
    one = 64'd1 << 61;
    tab[0] = atan_quarter();
    for (int i = 1; i < Steps; i++) begin
      tab[i] = atan_series(one >> i, 64'd0, 2 * i);
    end
    return tab;
  endfunction

  localparam atan_tab_t AtanTab = build_atan();
  localparam logic [63:0] PiQ41 = (4 * atan_quarter()) >> 20;
  localparam logic [63:0] PiHalf = PiQ41 >> 1;

endpackage

// ===== rtl/accel_tilt_majority_detector.sv =====
// From an accepted item to its result, each angle unit normalizes by shifting, runs
// two 40-step CORDIC passes with a serial gain scale between them, then a serial
// degree scale and divide; the window unit then counts the ones serially over the fill;
// an all-zero sample skips the angle work.
// Items are taken one at a time; a finished result waits in the output register while
// the next item is taken. Reset clears control, fill, count.
module accel_tilt_majority_detector
  import atmd_pkg::*;
#(
  parameter int unsigned MAX_WINDOW = 128
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // accel_x, accel_y, accel_z
  input  logic [3*SampleW-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // roll_angle, pitch_angle, sample_tilted, tilted, ones_in_window, window_fill
  output logic [((2*AngleW+2+2*$clog2(MAX_WINDOW+1)+7)/8)*8-1:0] m_axis_tdata,
  input  logic                  cfg_we_i,
  input  logic                  cfg_addr_i,
  input  logic [ThrW-1:0]       cfg_wdata_i
);

  localparam int unsigned CntW = $clog2(MAX_WINDOW + 1);
  localparam int unsigned PayW = 2 * AngleW + 2 + 2 * CntW;
  localparam int unsigned OutW = ((PayW + 7) / 8) * 8;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ANG  = 4'b0010,
    S_WIN  = 4'b0100,
    S_OUT  = 4'b1000
  } top_state_e;

  top_state_e state_q;
  logic [LenW-1:0] win_len_q;
  logic [ThrW-1:0] thr_q;
  logic roll_dn_q, pitch_dn_q, flag_q;
  logic m_valid_q;
  logic [OutW-1:0] m_data_q;

  logic accept, ang_start, roll_dn, pitch_dn, win_dn, both_dn, flag_d, tilted;
  logic out_load;
  logic signed [AngleW-1:0] roll, pitch;
  logic signed [AngleW:0] thr_s;
  logic [CntW-1:0] ones, fill;
  win_req_t win_req;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign ang_start     = accept;

  atmd_angle u_roll (
    .clk_i, .rst_ni,
    .start_i (ang_start),
    .a_i     ($signed(s_axis_tdata[2*SampleW-1:SampleW])),
    .b_i     ($signed(s_axis_tdata[SampleW-1:0])),
    .c_i     ($signed(s_axis_tdata[3*SampleW-1:2*SampleW])),
    .done_o  (roll_dn),
    .angle_o (roll)
  );

  atmd_angle u_pitch (
    .clk_i, .rst_ni,
    .start_i (ang_start),
    .a_i     ($signed(s_axis_tdata[SampleW-1:0])),
    .b_i     ($signed(s_axis_tdata[2*SampleW-1:SampleW])),
    .c_i     ($signed(s_axis_tdata[3*SampleW-1:2*SampleW])),
    .done_o  (pitch_dn),
    .angle_o (pitch)
  );

  assign both_dn = (roll_dn | roll_dn_q) & (pitch_dn | pitch_dn_q);
  assign thr_s   = $signed({2'b0, thr_q});
  assign flag_d  = (AngleW+1)'(roll) > thr_s || (AngleW+1)'(pitch) > thr_s;

  assign win_req.start = (state_q == S_ANG) && both_dn;
  assign win_req.flag  = flag_d;

  atmd_window #(
    .MaxWindow (MAX_WINDOW),
    .CntW      (CntW)
  ) u_window (
    .clk_i, .rst_ni,
    .req_i  (win_req),
    .len_i  (win_len_q),
    .done_o (win_dn),
    .ones_o (ones),
    .fill_o (fill)
  );

  assign tilted   = ({ones, 1'b0} > {1'b0, fill});
  assign out_load = (state_q == S_OUT) && (!m_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q <= WindowLengthRst;
      thr_q     <= TiltThresholdRst;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CfgWindowLength:  win_len_q <= cfg_wdata_i[LenW-1:0];
        CfgTiltThreshold: thr_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      roll_dn_q  <= 1'b0;
      pitch_dn_q <= 1'b0;
      flag_q     <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      if (out_load) m_valid_q <= 1'b1;
      else if (m_axis_tready) m_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            roll_dn_q  <= 1'b0;
            pitch_dn_q <= 1'b0;
            state_q    <= S_ANG;
          end
        end
        S_ANG: begin
          if (roll_dn) roll_dn_q <= 1'b1;
          if (pitch_dn) pitch_dn_q <= 1'b1;
          if (both_dn) begin
            flag_q  <= flag_d;
            state_q <= S_WIN;
          end
        end
        S_WIN: begin
          if (win_dn) state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_load) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // angles stay valid in the angle units until the next item starts
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= OutW'({fill, ones, tilted, flag_q, pitch, roll});
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

// ===== rtl/atmd_angle.sv =====
// Iterative atan2(a, |(b,c)|) unit: normalize, two CORDIC passes, serial scale and divide.
module atmd_angle
  import atmd_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [SampleW-1:0] a_i,
  input  logic signed [SampleW-1:0] b_i,
  input  logic signed [SampleW-1:0] c_i,
  output logic                      done_o,
  output logic signed [AngleW-1:0]  angle_o
);

  typedef enum logic [7:0] {
    A_IDLE = 8'b0000_0001,
    A_NORM = 8'b0000_0010,
    A_ROT1 = 8'b0000_0100,
    A_GAIN = 8'b0000_1000,
    A_ROT2 = 8'b0001_0000,
    A_MUL  = 8'b0010_0000,
    A_DIV  = 8'b0100_0000,
    A_DONE = 8'b1000_0000
  } ang_state_e;

  ang_state_e state_q, state_d;
  logic [5:0] cnt_q, cnt_d;
  logic [NormW-1:0] ua_q, ua_d, ub_q, ub_d, uc_q, uc_d;
  logic neg_q, neg_d;
  logic signed [RotW-1:0] x_q, x_d, y_q, y_d;
  logic signed [63:0] z_q, z_d;
  logic [63:0] acc_q, acc_d;
  logic [43:0] zq_q, zq_d;
  logic [AngleW-1:0] q_q, q_d;

  logic [SampleW:0] abs_a, abs_b, abs_c;
  logic signed [RotW-1:0] sx, sy, rx, ry;
  logic signed [63:0] rz;
  logic [63:0] term, sum, trial_d;
  logic [AngleW-1:0] capped;

  assign abs_a = a_i[SampleW-1] ? (SampleW+1)'(-$signed({a_i[SampleW-1], a_i}))
                                : {1'b0, a_i};
  assign abs_b = b_i[SampleW-1] ? (SampleW+1)'(-$signed({b_i[SampleW-1], b_i}))
                                : {1'b0, b_i};
  assign abs_c = c_i[SampleW-1] ? (SampleW+1)'(-$signed({c_i[SampleW-1], c_i}))
                                : {1'b0, c_i};

  // one CORDIC vectoring step, shift amount is the step index
  always_comb begin
    sx = x_q >>> cnt_q;
    sy = y_q >>> cnt_q;
    if (!y_q[RotW-1]) begin
      rx = x_q + sy;
      ry = y_q - sx;
      rz = z_q + $signed(AtanTab[cnt_q]);
    end else begin
      rx = x_q - sy;
      ry = y_q + sx;
      rz = z_q - $signed(AtanTab[cnt_q]);
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ua_d    = ua_q;
    ub_d    = ub_q;
    uc_d    = uc_q;
    neg_d   = neg_q;
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    acc_d   = acc_q;
    zq_d    = zq_q;
    q_d     = q_q;
    term    = '0;
    sum     = '0;
    trial_d = '0;
    unique case (state_q)
      A_IDLE: begin
        if (start_i) begin
          ua_d  = NormW'(abs_a);
          ub_d  = NormW'(abs_b);
          uc_d  = NormW'(abs_c);
          neg_d = a_i[SampleW-1];
          q_d   = '0;
          if (abs_a == '0 && abs_b == '0 && abs_c == '0) begin
            neg_d   = 1'b0;
            state_d = A_DONE;
          end else begin
            state_d = A_NORM;
          end
        end
      end
      A_NORM: begin
        if (ua_q[NormW-1] | ub_q[NormW-1] | uc_q[NormW-1]) begin
          x_d     = $signed({(RotW-NormW)'(0), ub_q});
          y_d     = $signed({(RotW-NormW)'(0), uc_q});
          cnt_d   = '0;
          state_d = A_ROT1;
        end else begin
          ua_d = ua_q << 1;
          ub_d = ub_q << 1;
          uc_d = uc_q << 1;
        end
      end
      A_ROT1: begin
        x_d   = rx;
        y_d   = ry;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(Steps - 1)) begin
          cnt_d   = '0;
          acc_d   = '0;
          state_d = A_GAIN;
        end
      end
      A_GAIN: begin
        // shift-add by the CORDIC gain constant, one bit per cycle
        term  = GainQ20[cnt_q[4:0]] ? ({(64-NormW)'(0), ua_q} << cnt_q) : '0;
        acc_d = acc_q + term;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(GainW - 1)) begin
          sum     = acc_d + (64'd1 << 19);
          y_d     = $signed({4'b0, sum[63:20]});
          z_d     = '0;
          cnt_d   = '0;
          state_d = A_ROT2;
        end
      end
      A_ROT2: begin
        x_d   = rx;
        y_d   = ry;
        z_d   = rz;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(Steps - 1)) begin
          zq_d    = rz[63] ? '0 : rz[63:20];
          acc_d   = '0;
          cnt_d   = '0;
          state_d = A_MUL;
        end
      end
      A_MUL: begin
        term  = DegMul[cnt_q[3:0]] ? ({20'b0, zq_q} << cnt_q) : '0;
        acc_d = acc_q + term;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(DegW - 1)) begin
          acc_d   = acc_q + term + PiHalf;
          cnt_d   = 6'(AngleW - 1);
          state_d = A_DIV;
        end
      end
      A_DIV: begin
        // restoring division by pi, one quotient bit per cycle
        trial_d = PiQ41 << cnt_q;
        if (acc_q >= trial_d) begin
          acc_d = acc_q - trial_d;
          q_d[cnt_q[3:0]] = 1'b1;
        end
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == '0) begin
          cnt_d   = '0;
          state_d = A_DONE;
        end
      end
      A_DONE: begin
        state_d = A_IDLE;
      end
      default: state_d = A_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      cnt_q   <= '0;
      q_q     <= '0;
      neg_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      q_q     <= q_d;
      neg_q   <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ua_q  <= ua_d;
    ub_q  <= ub_d;
    uc_q  <= uc_d;
    x_q   <= x_d;
    y_q   <= y_d;
    z_q   <= z_d;
    acc_q <= acc_d;
    zq_q  <= zq_d;
  end

  assign capped  = (q_q > AngleMax) ? AngleMax : q_q;
  assign angle_o = neg_q ? -$signed(capped) : $signed(capped);
  assign done_o  = (state_q == A_DONE);

endmodule

// ===== rtl/atmd_window.sv =====
// Flag history ring and serial ones count over the current window fill.
module atmd_window
  import atmd_pkg::*;
#(
  parameter int unsigned MaxWindow = 128,
  parameter int unsigned CntW      = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  win_req_t        req_i,
  input  logic [LenW-1:0] len_i,
  output logic            done_o,
  output logic [CntW-1:0] ones_o,
  output logic [CntW-1:0] fill_o
);

  localparam int unsigned AW = (MaxWindow > 1) ? $clog2(MaxWindow) : 1;
  localparam int unsigned LW = (CntW > LenW) ? CntW : LenW;

  typedef enum logic [1:0] {
    W_IDLE = 2'b01,
    W_CNT  = 2'b10
  } win_state_e;

  win_state_e state_q;
  logic hist_q [MaxWindow];
  logic [AW-1:0] wp_q, addr_q;
  logic [CntW-1:0] fill_q, left_q, ones_q;
  logic rvld_q, rdata_q;

  logic [LW-1:0] len_ext, len_eff, fill_ext, keep;
  logic [AW-1:0] wp_next, addr_prev;

  always_comb begin
    len_ext = LW'(len_i);
    if (len_ext == '0) len_eff = LW'(1);
    else if (len_ext > LW'(MaxWindow)) len_eff = LW'(MaxWindow);
    else len_eff = len_ext;
    fill_ext = LW'(fill_q);
    keep     = (fill_ext < len_eff) ? fill_ext : len_eff - LW'(1);
  end

  assign wp_next   = (wp_q == AW'(MaxWindow - 1)) ? '0 : wp_q + AW'(1);
  assign addr_prev = (addr_q == '0) ? AW'(MaxWindow - 1) : addr_q - AW'(1);

  always_ff @(posedge clk_i) begin
    if (req_i.start && state_q == W_IDLE) hist_q[wp_q] <= req_i.flag;
    rdata_q <= hist_q[addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= W_IDLE;
      wp_q    <= '0;
      addr_q  <= '0;
      fill_q  <= '0;
      left_q  <= '0;
      ones_q  <= '0;
      rvld_q  <= 1'b0;
    end else begin
      unique case (state_q)
        W_IDLE: begin
          rvld_q <= 1'b0;
          if (req_i.start) begin
            fill_q  <= CntW'(keep + LW'(1));
            left_q  <= CntW'(keep + LW'(1));
            addr_q  <= wp_q;
            wp_q    <= wp_next;
            ones_q  <= '0;
            state_q <= W_CNT;
          end
        end
        W_CNT: begin
          // read newest to oldest; data lands in the cycle after its address
          if (left_q != '0) begin
            addr_q <= addr_prev;
            left_q <= left_q - CntW'(1);
            rvld_q <= 1'b1;
          end else begin
            rvld_q <= 1'b0;
          end
          if (rvld_q) ones_q <= ones_q + CntW'(rdata_q);
          if (left_q == '0 && !rvld_q) state_q <= W_IDLE;
        end
        default: state_q <= W_IDLE;
      endcase
    end
  end

  assign done_o = (state_q == W_CNT) && (left_q == '0) && !rvld_q;
  assign ones_o = ones_q;
  assign fill_o = fill_q;

endmodule

// ===== rtl/atmd_checker.sv =====
// Port-level checks for the tilt detector, bound to the top level.
module atmd_checker #(
  parameter int unsigned CntW = 8,
  parameter int unsigned OutW = 48
) (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            s_axis_tvalid,
  input logic            s_axis_tready,
  input logic            m_axis_tvalid,
  input logic            m_axis_tready,
  input logic [OutW-1:0] m_axis_tdata
);

  logic [CntW-1:0] ones, fill;
  logic tilted;

  assign tilted = m_axis_tdata[31];
  assign ones   = m_axis_tdata[32+CntW-1:32];
  assign fill   = m_axis_tdata[32+2*CntW-1:32+CntW];

  // an accepted item keeps the input closed on the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after an accepted item");

  a_fill_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> fill != '0)
    else $error("result with empty window");

  a_ones_le_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ones <= fill)
    else $error("ones count above window fill");

  a_majority: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> tilted == ({ones, 1'b0} > {1'b0, fill}))
    else $error("majority flag disagrees with counts");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind accel_tilt_majority_detector atmd_checker #(
  .CntW ($clog2(MAX_WINDOW + 1)),
  .OutW ($bits(m_axis_tdata))
) u_atmd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
